// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file tmam_checker.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define TMAM_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define TMAM_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/tmam_pkg.sv -----
// Package for the trimmed-mean ADC monitor: sizes, payload and config types.
// No dependencies; imported by every module of the block except tmam_ram.
package tmam_pkg;

    localparam int SAMPLE_BITS    = 12;
    localparam int RING_DEPTH     = 10;
    localparam int SLOT_BITS      = $clog2(RING_DEPTH);
    localparam int TEMP_SLOTS     = 8;
    localparam int TEMP_SHIFT     = $clog2(TEMP_SLOTS);
    localparam int MEAN_SHIFT     = 3;
    localparam int SUM_BITS       = SAMPLE_BITS + $clog2(RING_DEPTH);
    localparam int TSUM_BITS      = SAMPLE_BITS + TEMP_SHIFT;
    localparam int GAIN_BITS      = 16;
    localparam int FRAC_BITS      = 8;
    localparam int OUT_BITS       = 16;
    localparam int TEMP_BITS      = 20;
    localparam int OFFSET_BITS    = 21;
    localparam int PROD_BITS      = SAMPLE_BITS + GAIN_BITS;
    localparam int SCALED_BITS    = PROD_BITS - FRAC_BITS;
    localparam int TPROD_BITS     = GAIN_BITS + SAMPLE_BITS + 1;
    localparam int TEMP_SUM_BITS  = TPROD_BITS + 1;
    localparam int LOW_LIMIT      = 10;
    localparam int ONE_Q88        = 256;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = OFFSET_BITS;

    // Channels that get the trimmed mean.
    localparam int CH_NEG  = 0;
    localparam int CH_POS  = 1;
    localparam int CH_CUR  = 2;
    localparam int TRIM_CH = 3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_CURRENT_GAIN = 0,
        REG_VOLTAGE_GAIN = 1,
        REG_TEMP_GAIN    = 2,
        REG_TEMP_OFFSET  = 3
    } tmam_reg_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample_temp;
        logic [SAMPLE_BITS-1:0] sample_neg;
        logic [SAMPLE_BITS-1:0] sample_pos;
        logic [SAMPLE_BITS-1:0] sample_current;
    } tmam_in_t;

    localparam int ROW_BITS = $bits(tmam_in_t);

    typedef struct packed {
        logic [OUT_BITS-1:0]    current_value;
        logic [OUT_BITS-1:0]    neg_value;
        logic [OUT_BITS-1:0]    pos_value;
        logic [OUT_BITS-1:0]    battery_voltage;
        logic                   reverse_flag;
        logic [SAMPLE_BITS-1:0] temp_average;
        logic [TEMP_BITS-1:0]   temperature;
    } tmam_out_t;

    typedef struct packed {
        logic [GAIN_BITS-1:0]          current_gain;
        logic [GAIN_BITS-1:0]          voltage_gain;
        logic signed [GAIN_BITS-1:0]   temp_gain;
        logic signed [OFFSET_BITS-1:0] temp_offset;
    } tmam_cfg_t;

endpackage

// ----- rtl/core/tmam_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tmam_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/tmam_queue.sv -----
// Front end: accepts conversions and buffers them in a short queue for the back end.
// Depends on tmam_pkg.
module tmam_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tmam_pkg::tmam_in_t s_data,
    output logic              q_valid,
    input  logic              q_ready,
    output tmam_pkg::tmam_in_t q_data
);
    import tmam_pkg::*;

    tmam_in_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QCNT_BITS-1:0] count_reg;
    logic                 push;
    logic                 pop;

    assign s_ready = (count_reg != QCNT_BITS'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = entry_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                entry_reg[wr_ptr_reg] <= s_data;
                wr_ptr_reg <= (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/core/tmam_back.sv -----
// Back end: owns the sample ring, sweeps it for trimmed means, scales and
// registers the result. Depends on tmam_pkg and tmam_ram.
module tmam_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  tmam_pkg::tmam_cfg_t cfg,
    input  logic                q_valid,
    output logic                q_ready,
    input  tmam_pkg::tmam_in_t  q_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tmam_pkg::tmam_out_t m_data
);
    import tmam_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LAST,
        S_TRIM,
        S_MUL,
        S_DONE
    } state_t;

    localparam logic signed [TEMP_SUM_BITS-1:0] ONE_S = TEMP_SUM_BITS'(ONE_Q88);
    localparam logic signed [TEMP_SUM_BITS-1:0] MAX_S =
        TEMP_SUM_BITS'((64'd1 << TEMP_BITS) - 64'd1);

    state_t                  state_reg;
    logic [SLOT_BITS-1:0]    slot_reg;
    logic [SLOT_BITS-1:0]    rd_cnt_reg;
    logic [SLOT_BITS-1:0]    row_idx_reg;
    logic [RING_DEPTH-1:0]   valid_reg;
    logic                    row_ok_reg;
    logic [SUM_BITS-1:0]     sum_reg  [TRIM_CH];
    logic [SAMPLE_BITS-1:0]  lo_reg   [TRIM_CH];
    logic [SAMPLE_BITS-1:0]  hi_reg   [TRIM_CH];
    logic [SAMPLE_BITS-1:0]  mean_reg [TRIM_CH];
    logic [PROD_BITS-1:0]    prod_reg [TRIM_CH];
    logic [TSUM_BITS-1:0]    tsum_reg;
    logic [SAMPLE_BITS-1:0]  tavg_reg;
    logic signed [TPROD_BITS-1:0] tprod_reg;
    logic                    m_valid_reg;
    tmam_out_t               m_data_reg;

    logic                    ram_wr_en;
    logic                    ram_rd_en;
    logic [ROW_BITS-1:0]     ram_rd_data;

    tmam_in_t                row;
    logic [SAMPLE_BITS-1:0]  row_val  [TRIM_CH];
    logic [SUM_BITS-1:0]     sum_next [TRIM_CH];
    logic [SAMPLE_BITS-1:0]  lo_next  [TRIM_CH];
    logic [SAMPLE_BITS-1:0]  hi_next  [TRIM_CH];
    logic [SUM_BITS-1:0]     diff     [TRIM_CH];
    logic [SAMPLE_BITS-1:0]  mean_next[TRIM_CH];
    logic [TSUM_BITS-1:0]    tsum_next;
    logic                    acc_en;
    logic [OUT_BITS-1:0]     sat      [TRIM_CH];
    logic [SCALED_BITS-1:0]  scaled   [TRIM_CH];
    logic [OUT_BITS-1:0]     cur_val;
    logic [OUT_BITS-1:0]     neg_val;
    logic [OUT_BITS-1:0]     pos_val;
    logic signed [TEMP_SUM_BITS-1:0] t_sum;
    tmam_out_t               res;

    tmam_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (slot_reg),
        .wr_data (q_data),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_cnt_reg),
        .rd_data (ram_rd_data)
    );

    assign q_ready   = (state_reg == S_IDLE);
    assign ram_wr_en = q_valid && q_ready;
    assign ram_rd_en = (state_reg == S_READ);
    assign acc_en    = ((state_reg == S_READ) && (rd_cnt_reg != '0)) || (state_reg == S_LAST);

    // Ring accumulation; a row never written reads as zero.
    always_comb begin
        row = row_ok_reg ? tmam_in_t'(ram_rd_data) : '0;
        row_val[CH_NEG] = row.sample_neg;
        row_val[CH_POS] = row.sample_pos;
        row_val[CH_CUR] = row.sample_current;
        for (int ch = 0; ch < TRIM_CH; ch++) begin
            sum_next[ch]  = sum_reg[ch] + SUM_BITS'(row_val[ch]);
            lo_next[ch]   = (row_val[ch] < lo_reg[ch]) ? row_val[ch] : lo_reg[ch];
            hi_next[ch]   = (row_val[ch] > hi_reg[ch]) ? row_val[ch] : hi_reg[ch];
            diff[ch]      = sum_reg[ch] - SUM_BITS'(lo_reg[ch]) - SUM_BITS'(hi_reg[ch]);
            mean_next[ch] = SAMPLE_BITS'(diff[ch] >> MEAN_SHIFT);
        end
        tsum_next = (row_idx_reg < SLOT_BITS'(TEMP_SLOTS)) ?
                    tsum_reg + TSUM_BITS'(row.sample_temp) : tsum_reg;
    end

    // Saturate, threshold and combine the registered products.
    always_comb begin
        for (int ch = 0; ch < TRIM_CH; ch++) begin
            scaled[ch] = prod_reg[ch][PROD_BITS-1:FRAC_BITS];
            sat[ch]    = (|scaled[ch][SCALED_BITS-1:OUT_BITS]) ?
                         '1 : scaled[ch][OUT_BITS-1:0];
        end
        cur_val = (sat[CH_CUR] < OUT_BITS'(LOW_LIMIT))  ? '0 : sat[CH_CUR];
        neg_val = (sat[CH_NEG] <= OUT_BITS'(LOW_LIMIT)) ? '0 : sat[CH_NEG];
        pos_val = (sat[CH_POS] <= OUT_BITS'(LOW_LIMIT)) ? '0 : sat[CH_POS];
        t_sum   = {{(TEMP_SUM_BITS - TPROD_BITS){tprod_reg[TPROD_BITS-1]}}, tprod_reg} +
                  {{(TEMP_SUM_BITS - OFFSET_BITS){cfg.temp_offset[OFFSET_BITS-1]}},
                   cfg.temp_offset};

        res.current_value   = cur_val;
        res.neg_value       = neg_val;
        res.pos_value       = pos_val;
        res.reverse_flag    = (neg_val > pos_val);
        res.battery_voltage = (neg_val > pos_val) ? '0 : pos_val - neg_val;
        res.temp_average    = tavg_reg;
        if (t_sum <= ONE_S) begin
            res.temperature = '0;
        end else if (t_sum > MAX_S) begin
            res.temperature = '1;
        end else begin
            res.temperature = t_sum[TEMP_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            slot_reg    <= '0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // Drop a taken result; the done state reloads the register itself.
            if (m_ready && (state_reg != S_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            if (acc_en) begin
                for (int ch = 0; ch < TRIM_CH; ch++) begin
                    sum_reg[ch] <= sum_next[ch];
                    lo_reg[ch]  <= lo_next[ch];
                    hi_reg[ch]  <= hi_next[ch];
                end
                tsum_reg <= tsum_next;
            end
            case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        valid_reg[slot_reg] <= 1'b1;
                        slot_reg <= (slot_reg == SLOT_BITS'(RING_DEPTH - 1)) ?
                                    '0 : slot_reg + 1'b1;
                        rd_cnt_reg <= '0;
                        for (int ch = 0; ch < TRIM_CH; ch++) begin
                            sum_reg[ch] <= '0;
                            lo_reg[ch]  <= '1;
                            hi_reg[ch]  <= '0;
                        end
                        tsum_reg  <= '0;
                        state_reg <= S_READ;
                    end
                end
                S_READ: begin
                    row_ok_reg  <= valid_reg[rd_cnt_reg];
                    row_idx_reg <= rd_cnt_reg;
                    if (rd_cnt_reg == SLOT_BITS'(RING_DEPTH - 1)) begin
                        state_reg <= S_LAST;
                    end else begin
                        rd_cnt_reg <= rd_cnt_reg + 1'b1;
                    end
                end
                S_LAST: begin
                    state_reg <= S_TRIM;
                end
                S_TRIM: begin
                    for (int ch = 0; ch < TRIM_CH; ch++) begin
                        mean_reg[ch] <= mean_next[ch];
                    end
                    tavg_reg  <= tsum_reg[TSUM_BITS-1:TEMP_SHIFT];
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    prod_reg[CH_NEG] <= PROD_BITS'(mean_reg[CH_NEG]) *
                                        PROD_BITS'(cfg.voltage_gain);
                    prod_reg[CH_POS] <= PROD_BITS'(mean_reg[CH_POS]) *
                                        PROD_BITS'(cfg.voltage_gain);
                    prod_reg[CH_CUR] <= PROD_BITS'(mean_reg[CH_CUR]) *
                                        PROD_BITS'(cfg.current_gain);
                    tprod_reg <= TPROD_BITS'($signed(cfg.temp_gain)) *
                                 TPROD_BITS'($signed({1'b0, tavg_reg}));
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    // Hold here until the output register is free.
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg  <= res;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- rtl/core/trimmed_mean_adc_monitor.sv -----
// Top level of the trimmed-mean ADC monitor: config registers, front queue, back end.
// Depends on tmam_pkg, tmam_queue and tmam_back.
// Use:
//   s_valid/s_ready/s_data carry one completed four-channel conversion per
//   transfer (temperature, negative, positive, current counts).
//   m_valid/m_ready/m_data carry one result per conversion: scaled trimmed
//   means, battery voltage, reverse flag, temperature average and temperature.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the four gain and offset
//   registers; cfg_ready is always high, and unknown indexes are dropped.
//   Write configuration only while no conversion is in flight.
// Flow:
//   each conversion moves from the queue to the back end, which writes the ring,
//   reads its ten rows through the one RAM read port, folds in the last row,
//   trims, multiplies, then registers the result before it takes the next one.
// Reset:
//   aresetn low clears the ring valid bits, write slot, queue and output, and
//   loads the register reset values; the ring reads as all zero at once.
// Stall:
//   A held result stays on m_data; the back end finishes the next item and
//   waits, and the two-entry queue keeps accepting until it fills.
module trimmed_mean_adc_monitor (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  tmam_pkg::tmam_in_t                    s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output tmam_pkg::tmam_out_t                   m_data,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [tmam_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [tmam_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import tmam_pkg::*;

    tmam_cfg_t cfg_reg;
    logic      q_valid;
    logic      q_ready;
    tmam_in_t  q_data;

    // Configuration is always taken; only the low bits of each register are kept.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.current_gain <= GAIN_BITS'(ONE_Q88);
            cfg_reg.voltage_gain <= GAIN_BITS'(ONE_Q88);
            cfg_reg.temp_gain    <= GAIN_BITS'(ONE_Q88);
            cfg_reg.temp_offset  <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_CURRENT_GAIN: cfg_reg.current_gain <= cfg_data[GAIN_BITS-1:0];
                REG_VOLTAGE_GAIN: cfg_reg.voltage_gain <= cfg_data[GAIN_BITS-1:0];
                REG_TEMP_GAIN:    cfg_reg.temp_gain    <= cfg_data[GAIN_BITS-1:0];
                REG_TEMP_OFFSET:  cfg_reg.temp_offset  <= cfg_data[OFFSET_BITS-1:0];
                default: begin
                    // Drop writes to unknown indexes.
                end
            endcase
        end
    end

    // Front: take conversions and buffer them.
    tmam_queue u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data)
    );

    // Back: ring update, sweep, scaling and result register.
    tmam_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ----- rtl/core/tmam_checker.sv -----
// Port-level checker for the trimmed-mean ADC monitor, bound to the top level.
// Depends on tmam_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tmam_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  tmam_pkg::tmam_in_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  tmam_pkg::tmam_out_t m_data
);
    import tmam_pkg::*;

    `TMAM_ASSERT_NXT(a_in_hold, aclk, aresetn,
        s_valid && !s_ready,
        s_valid && $stable(s_data),
        "input transfer changed while waiting")

    `TMAM_ASSERT_NXT(a_out_hold, aclk, aresetn,
        m_valid && !m_ready,
        m_valid && $stable(m_data),
        "result changed while stalled")

    `TMAM_ASSERT_IMP(a_battery, aclk, aresetn, m_valid,
        (m_data.reverse_flag == (m_data.neg_value > m_data.pos_value)) &&
        (m_data.reverse_flag ? (m_data.battery_voltage == '0) :
         (m_data.battery_voltage == m_data.pos_value - m_data.neg_value)),
        "battery voltage or reverse flag inconsistent")

    `TMAM_ASSERT_IMP(a_low_cut, aclk, aresetn, m_valid,
        (m_data.current_value == '0 || m_data.current_value >= LOW_LIMIT) &&
        (m_data.neg_value == '0 || m_data.neg_value > LOW_LIMIT) &&
        (m_data.pos_value == '0 || m_data.pos_value > LOW_LIMIT),
        "low reading not forced to zero")

    `TMAM_ASSERT_IMP(a_temp_floor, aclk, aresetn, m_valid,
        m_data.temperature == '0 || m_data.temperature > ONE_Q88,
        "temperature at or below one not forced to zero")

endmodule

bind trimmed_mean_adc_monitor tmam_checker u_tmam_checker (.*);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for trimmed_mean_adc_monitor: scoreboard class and stimulus tasks.
// Depends on tmam_pkg and the monitor RTL.
module tb_top;
    import tmam_pkg::*;

    // Channel columns of the bench's own copy of the sample ring.
    localparam int CHAN_TEMP  = 0;
    localparam int CHAN_NEG   = 1;
    localparam int CHAN_POS   = 2;
    localparam int CHAN_CUR   = 3;
    localparam int NUM_CHAN   = 4;
    localparam longint MAX16  = 64'hFFFF;
    localparam longint MAX20  = 64'hFFFFF;
    localparam logic [SAMPLE_BITS-1:0] FULL_COUNT = '1;

    localparam int PHASES      = 9;
    localparam int PHASE_ITEMS = 209;
    localparam int BASE_EVERY  = 40;
    localparam int DRAIN_WAIT  = 40;
    localparam int CYCLE_LIMIT = 400000;

    // Tracks the monitor's ring and registers, and holds readings still due on m_data.
    class reading_tracker;
        logic [SAMPLE_BITS-1:0]        ring [RING_DEPTH][NUM_CHAN];
        int unsigned                   slot;
        logic [GAIN_BITS-1:0]          current_gain;
        logic [GAIN_BITS-1:0]          voltage_gain;
        logic signed [GAIN_BITS-1:0]   temp_slope;
        logic signed [OFFSET_BITS-1:0] temp_offset;
        tmam_out_t                     pending [$];
        int unsigned                   failures;

        function new();
            foreach (ring[k, c]) ring[k][c] = '0;
            slot         = 0;
            current_gain = 16'd256;
            voltage_gain = 16'd256;
            temp_slope   = 16'sd256;
            temp_offset  = '0;
            failures     = 0;
        endfunction

        function void set_register(logic [CFG_INDEX_BITS-1:0] index,
                                   logic [CFG_DATA_BITS-1:0] data);
            case (index)
                REG_CURRENT_GAIN: current_gain = data[GAIN_BITS-1:0];
                REG_VOLTAGE_GAIN: voltage_gain = data[GAIN_BITS-1:0];
                REG_TEMP_GAIN:    temp_slope   = data[GAIN_BITS-1:0];
                REG_TEMP_OFFSET:  temp_offset  = data[OFFSET_BITS-1:0];
                default:          ;
            endcase
        endfunction

        // Ring sum less its smallest and largest slot, over 8, scaled by a Q8.8 gain.
        function logic [OUT_BITS-1:0] scaled_mean(int ch, logic [GAIN_BITS-1:0] gain);
            int unsigned       sum;
            int unsigned       lo;
            int unsigned       hi;
            longint unsigned   prod;
            sum = 0;
            lo  = 32'hFFFF_FFFF;
            hi  = 0;
            for (int k = 0; k < RING_DEPTH; k++) begin
                if (ring[k][ch] < lo) lo = ring[k][ch];
                if (ring[k][ch] > hi) hi = ring[k][ch];
                sum += ring[k][ch];
            end
            sum  = (sum - lo - hi) >> MEAN_SHIFT;
            prod = sum;
            prod = (prod * gain) >> FRAC_BITS;
            return (prod > MAX16) ? OUT_BITS'(MAX16) : OUT_BITS'(prod);
        endfunction

        function void add_conversion(tmam_in_t conv);
            tmam_out_t              r;
            int unsigned            tsum;
            logic [SAMPLE_BITS-1:0] tavg;
            longint                 t;
            ring[slot][CHAN_TEMP] = conv.sample_temp;
            ring[slot][CHAN_NEG]  = conv.sample_neg;
            ring[slot][CHAN_POS]  = conv.sample_pos;
            ring[slot][CHAN_CUR]  = conv.sample_current;
            slot = (slot + 1 >= RING_DEPTH) ? 0 : slot + 1;

            r.current_value = scaled_mean(CHAN_CUR, current_gain);
            if (r.current_value < LOW_LIMIT) r.current_value = '0;
            r.neg_value = scaled_mean(CHAN_NEG, voltage_gain);
            if (r.neg_value <= LOW_LIMIT) r.neg_value = '0;
            r.pos_value = scaled_mean(CHAN_POS, voltage_gain);
            if (r.pos_value <= LOW_LIMIT) r.pos_value = '0;
            if (r.neg_value > r.pos_value) begin
                r.reverse_flag    = 1'b1;
                r.battery_voltage = '0;
            end else begin
                r.reverse_flag    = 1'b0;
                r.battery_voltage = r.pos_value - r.neg_value;
            end

            tsum = 0;
            for (int k = 0; k < TEMP_SLOTS; k++) tsum += ring[k][CHAN_TEMP];
            tavg = SAMPLE_BITS'(tsum >> TEMP_SHIFT);
            r.temp_average = tavg;
            t = longint'(temp_slope) * longint'(tavg) + longint'(temp_offset);
            if (t <= ONE_Q88) t = 0;
            if (t > MAX20) t = MAX20;
            r.temperature = TEMP_BITS'(t);
            pending.push_back(r);
        endfunction

        function void check_field(string name, longint unsigned want, longint unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                failures++;
            end
        endfunction

        function void check_reading(tmam_out_t got);
            tmam_out_t want;
            if (pending.size() == 0) begin
                $error("reading on m_data with no conversion outstanding");
                failures++;
                return;
            end
            want = pending.pop_front();
            check_field("current_value",   want.current_value,   got.current_value);
            check_field("neg_value",       want.neg_value,       got.neg_value);
            check_field("pos_value",       want.pos_value,       got.pos_value);
            check_field("battery_voltage", want.battery_voltage, got.battery_voltage);
            check_field("reverse_flag",    want.reverse_flag,    got.reverse_flag);
            check_field("temp_average",    want.temp_average,    got.temp_average);
            check_field("temperature",     want.temperature,     got.temperature);
        endfunction
    endclass

    logic                      aclk = 1'b0;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    tmam_in_t                  s_data;
    logic                      m_valid;
    logic                      m_ready;
    tmam_out_t                 m_data;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    reading_tracker tracker = new();

    // Percent of cycles in which each side holds off; changed between phases.
    int send_idle = 7;
    int recv_idle = 56;
    int cycles    = 0;

    always #2 aclk = ~aclk;

    trimmed_mean_adc_monitor u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Watchdog: a correct run finishes far below this many cycles.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side: check every transfer, then pick the next cycle's ready at random.
    // Values read right after the edge are the ones the block saw at that edge.
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) tracker.check_reading(m_data);
            m_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // Offer one conversion, possibly after a random gap, and hold it until the transfer.
    // Valid is only dropped inside a gap, so back-to-back items keep it high.
    task automatic send_conv(input logic [SAMPLE_BITS-1:0] temp, input logic [SAMPLE_BITS-1:0] neg,
                             input logic [SAMPLE_BITS-1:0] pos, input logic [SAMPLE_BITS-1:0] cur);
        tmam_in_t conv;
        conv.sample_temp    = temp;
        conv.sample_neg     = neg;
        conv.sample_pos     = pos;
        conv.sample_current = cur;
        while ($urandom_range(0, 99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= conv;
        do @(posedge aclk); while (!s_ready);
        tracker.add_conversion(conv);
    endtask

    // Drop valid and wait until every outstanding reading has come back.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (tracker.pending.size() != 0);
    endtask

    // One register write; the caller lowers cfg_valid after the last of a batch.
    task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] index,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        tracker.set_register(index, data);
    endtask

    // Put junk in the bits above a 16-bit register so that the block must ignore them.
    function automatic logic [CFG_DATA_BITS-1:0] word16(logic [GAIN_BITS-1:0] value);
        return {(CFG_DATA_BITS - GAIN_BITS)'($urandom), value};
    endfunction

    function automatic logic [GAIN_BITS-1:0] random_gain();
        if ($urandom_range(0, 3) == 0) return GAIN_BITS'($urandom);
        return GAIN_BITS'($urandom_range(16, 1024));
    endfunction

    // Phase 0 keeps reset values, phase 1 the top extremes, phase 2 the bottom ones,
    // the rest random settings. Every phase but the first also writes an unused index.
    task automatic configure_phase(input int phase);
        logic [GAIN_BITS-1:0]     slope;
        logic [OFFSET_BITS-1:0]   offset;
        if (phase == 0) return;
        case (phase)
            1: begin
                cfg_write(REG_CURRENT_GAIN, word16(16'hFFFF));
                cfg_write(REG_VOLTAGE_GAIN, word16(16'hFFFF));
                cfg_write(REG_TEMP_GAIN,    word16(16'h7FFF));
                cfg_write(REG_TEMP_OFFSET,  21'h0F_FFFF);
            end
            2: begin
                cfg_write(REG_CURRENT_GAIN, word16(16'h0000));
                cfg_write(REG_VOLTAGE_GAIN, word16(16'h0000));
                cfg_write(REG_TEMP_GAIN,    word16(16'h8000));
                cfg_write(REG_TEMP_OFFSET,  21'h10_0000);
            end
            default: begin
                if ($urandom_range(0, 3) == 0) slope = GAIN_BITS'($urandom);
                else slope = GAIN_BITS'(int'($urandom_range(0, 1200)) - 200);
                if ($urandom_range(0, 1) == 0) offset = OFFSET_BITS'($urandom);
                else offset = OFFSET_BITS'(int'($urandom_range(0, 131072)) - 65536);
                cfg_write(REG_CURRENT_GAIN, word16(random_gain()));
                cfg_write(REG_VOLTAGE_GAIN, word16(random_gain()));
                cfg_write(REG_TEMP_GAIN,    word16(slope));
                cfg_write(REG_TEMP_OFFSET,  offset);
            end
        endcase
        // The block must drop this one without touching any register.
        cfg_write(CFG_INDEX_BITS'($urandom_range(REG_TEMP_OFFSET + 1, 255)),
                  CFG_DATA_BITS'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // Mostly a noisy level around a per-channel base so the trimmed means settle
    // near it; some full-range spikes and some counts around the low cut-off.
    function automatic logic [SAMPLE_BITS-1:0] draw_count(logic [SAMPLE_BITS-1:0] base);
        int pick;
        int v;
        pick = $urandom_range(0, 9);
        if (pick < 2) return SAMPLE_BITS'($urandom);
        if (pick < 4) return SAMPLE_BITS'($urandom_range(0, 24));
        v = int'(base) + int'($urandom_range(0, 128)) - 64;
        if (v < 0) v = 0;
        if (v > FULL_COUNT) v = FULL_COUNT;
        return SAMPLE_BITS'(v);
    endfunction

    initial begin
        logic [SAMPLE_BITS-1:0] base [NUM_CHAN];
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        aresetn   <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part, reset register values. Start on the zero ring, then one
        // full-scale sample among zeros (trimmed away), then a ring full of maximums.
        send_conv('0, '0, '0, '0);
        for (int i = 0; i < RING_DEPTH; i++)
            send_conv(FULL_COUNT, FULL_COUNT, FULL_COUNT, FULL_COUNT);
        // Negative terminal above positive: reverse flag, alternating bit patterns.
        for (int i = 0; i < 5; i++)
            send_conv(12'h555, FULL_COUNT, '0, 12'hAAA);
        // Walk the means down onto the low cut-offs: 9, 10 and 11 counts.
        for (int i = 0; i < 8; i++)
            send_conv(12'd260 + 12'(i), 12'd10, 12'd11, 12'd9 + 12'(i % 3));

        // Random phases: three idle patterns, each under three register settings.
        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            case (phase / 3)
                0: begin send_idle = 7;  recv_idle = 56; end
                1: begin send_idle = 56; recv_idle = 7;  end
                default: begin send_idle = 0; recv_idle = 0; end
            endcase
            configure_phase(phase);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i % BASE_EVERY == 0) begin
                    foreach (base[c]) begin
                        if ($urandom_range(0, 3) == 0) base[c] = SAMPLE_BITS'($urandom_range(0, 40));
                        else base[c] = SAMPLE_BITS'($urandom);
                    end
                end
                send_conv(draw_count(base[CHAN_TEMP]), draw_count(base[CHAN_NEG]),
                          draw_count(base[CHAN_POS]), draw_count(base[CHAN_CUR]));
            end
        end

        // Let any stray late reading show up before the verdict.
        drain();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (tracker.failures == 0 && tracker.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/tmam_pkg.sv
rtl/core/tmam_ram.sv
rtl/core/tmam_queue.sv
rtl/core/tmam_back.sv
rtl/core/trimmed_mean_adc_monitor.sv
rtl/core/tmam_checker.sv
tb/sv/tb_top.sv
